// File: hdl/tli_pkg.sv
package tli_pkg;

   // Sizes
   localparam int TAPE_DEPTH = 65536;
   localparam int NEST_DEPTH = 32;
   localparam int PROG_DEPTH = 65536;

   localparam int TAPE_AW   = $clog2(TAPE_DEPTH);
   localparam int FILL_W    = TAPE_AW + 1;
   localparam int STACK_CW  = $clog2(NEST_DEPTH + 1);
   localparam int STACK_IW  = (NEST_DEPTH > 1) ? $clog2(NEST_DEPTH) : 1;
   localparam int SEQ_W     = ($clog2(PROG_DEPTH + 1) > 17) ? $clog2(PROG_DEPTH + 1) : 17;
   localparam int POS_W     = 16;
   localparam int SKIP_W    = 16;

   localparam logic [TAPE_AW-1:0] TAPE_TOP = TAPE_AW'(TAPE_DEPTH - 1);
   localparam logic [SKIP_W-1:0]  SKIP_MAX = {SKIP_W{1'b1}};

   // Program symbols
   localparam logic [7:0] SYM_RIGHT = 8'h3E;
   localparam logic [7:0] SYM_LEFT  = 8'h3C;
   localparam logic [7:0] SYM_INC   = 8'h2B;
   localparam logic [7:0] SYM_DEC   = 8'h2D;
   localparam logic [7:0] SYM_PRINT = 8'h2A;
   localparam logic [7:0] SYM_OPEN  = 8'h28;
   localparam logic [7:0] SYM_CLOSE = 8'h29;

   typedef enum logic [2:0] {
      ERR_NONE       = 3'd0,
      ERR_TOP        = 3'd1,
      ERR_BOTTOM     = 3'd2,
      ERR_UNMATCHED  = 3'd3,
      ERR_STACK_FULL = 3'd4
   } error_code_type;

   typedef struct packed {
      logic [POS_W-1:0] position;
      logic [7:0]       symbol;
   } req_type;

   typedef struct packed {
      logic [POS_W-1:0] next_position;
      logic             print_valid;
      logic [7:0]       print_byte;
      error_code_type   error_code;
      logic             halted;
   } rsp_type;

   // Tape memory access for one executed symbol
   typedef struct packed {
      logic               wr_en;
      logic [TAPE_AW-1:0] wr_addr;
      logic [7:0]         wr_data;
      logic               rd_en;
      logic [TAPE_AW-1:0] rd_addr;
   } tape_cmd_type;

   typedef struct packed {
      logic             push;
      logic             pop;
      logic [POS_W-1:0] data;
   } stack_cmd_type;

   typedef struct packed {
      logic             empty;
      logic             full;
      logic [POS_W-1:0] top;
   } stack_status_type;

   // Interpreter state held next to the tape memory
   typedef struct packed {
      logic [TAPE_AW-1:0] cell_ptr;
      logic [FILL_W-1:0]  filled;
      logic [7:0]         cur_cell;
      logic               load_pending;
      logic               load_fresh;
      logic [SKIP_W-1:0]  skip_depth;
      logic               halt;
   } exec_state_type;

endpackage

// File: hdl/tli_tape_ram.sv
module tli_tape_ram (
   input  logic                          clock,
   input  tli_pkg::tape_cmd_type         cmd,
   output logic [7:0]                    rd_data
);

   logic [7:0] mem_ff [tli_pkg::TAPE_DEPTH];
   logic [7:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (cmd.wr_en) begin
         mem_ff[cmd.wr_addr] <= cmd.wr_data;
      end
   end

   // Read data holds until the next read
   always_ff @(posedge clock) begin
      if (cmd.rd_en) begin
         rd_data_ff <= mem_ff[cmd.rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: hdl/tli_loop_stack.sv
module tli_loop_stack (
   input  logic                         clock,
   input  logic                         reset,
   input  tli_pkg::stack_cmd_type       cmd,
   output tli_pkg::stack_status_type    status
);

   logic [tli_pkg::POS_W-1:0]    stack_ff [tli_pkg::NEST_DEPTH];
   logic [tli_pkg::STACK_CW-1:0] count_ff;
   logic [tli_pkg::STACK_CW-1:0] count_in;
   logic [tli_pkg::STACK_CW-1:0] top_sum;

   always_comb begin
      count_in = count_ff;
      if (cmd.push) begin
         count_in = count_ff + tli_pkg::STACK_CW'(1);
      end else if (cmd.pop) begin
         count_in = count_ff - tli_pkg::STACK_CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.push) begin
         stack_ff[count_ff[tli_pkg::STACK_IW-1:0]] <= cmd.data;
      end
   end

   assign top_sum      = count_ff - tli_pkg::STACK_CW'(1);
   assign status.empty = (count_ff == '0);
   assign status.full  = (count_ff == tli_pkg::STACK_CW'(tli_pkg::NEST_DEPTH));
   assign status.top   = stack_ff[top_sum[tli_pkg::STACK_IW-1:0]];

endmodule

// File: hdl/tli_exec.sv
module tli_exec (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         execute,
   input  tli_pkg::req_type             item,
   input  logic [7:0]                   rd_data,
   input  tli_pkg::stack_status_type    stack_status,
   output tli_pkg::rsp_type             result,
   output tli_pkg::tape_cmd_type        tape_cmd,
   output tli_pkg::stack_cmd_type       stack_cmd
);

   tli_pkg::exec_state_type      state_ff;
   tli_pkg::exec_state_type      state_in;
   tli_pkg::exec_state_type      state_next;
   tli_pkg::tape_cmd_type        tape_raw;
   tli_pkg::stack_cmd_type       stack_raw;
   tli_pkg::error_code_type      err;
   logic [7:0]                   eff_cell;
   logic [tli_pkg::SEQ_W-1:0]    pos_ext;
   logic [tli_pkg::POS_W-1:0]    seq_next;
   logic [tli_pkg::FILL_W-1:0]   cp_up;
   logic [tli_pkg::FILL_W-1:0]   filled_grow;

   // Current cell: a move leaves the new cell in the read register (or fresh zero)
   assign eff_cell = state_ff.load_pending ?
                     (state_ff.load_fresh ? 8'd0 : rd_data) : state_ff.cur_cell;

   assign pos_ext  = tli_pkg::SEQ_W'(item.position) + tli_pkg::SEQ_W'(1);
   assign seq_next = (pos_ext >= tli_pkg::SEQ_W'(tli_pkg::PROG_DEPTH)) ?
                     '0 : pos_ext[tli_pkg::POS_W-1:0];

   // Cells below the fill mark hold valid data; leaving a cell writes it back
   assign cp_up       = tli_pkg::FILL_W'(state_ff.cell_ptr) + tli_pkg::FILL_W'(1);
   assign filled_grow = (cp_up > state_ff.filled) ? cp_up : state_ff.filled;

   always_comb begin
      state_next              = state_ff;
      state_next.cur_cell     = eff_cell;
      state_next.load_pending = 1'b0;
      state_next.load_fresh   = 1'b0;
      err                     = tli_pkg::ERR_NONE;

      tape_raw.wr_en   = 1'b0;
      tape_raw.wr_addr = state_ff.cell_ptr;
      tape_raw.wr_data = eff_cell;
      tape_raw.rd_en   = 1'b0;
      tape_raw.rd_addr = state_ff.cell_ptr;

      stack_raw.push = 1'b0;
      stack_raw.pop  = 1'b0;
      stack_raw.data = seq_next;

      result.next_position = seq_next;
      result.print_valid   = 1'b0;
      result.print_byte    = 8'd0;

      if (state_ff.halt) begin
         result.next_position = item.position;
      end else if (state_ff.skip_depth != '0) begin
         if (item.symbol == tli_pkg::SYM_OPEN) begin
            if (state_ff.skip_depth != tli_pkg::SKIP_MAX) begin
               state_next.skip_depth = state_ff.skip_depth + tli_pkg::SKIP_W'(1);
            end
         end else if (item.symbol == tli_pkg::SYM_CLOSE) begin
            state_next.skip_depth = state_ff.skip_depth - tli_pkg::SKIP_W'(1);
         end
      end else begin
         case (item.symbol)
            tli_pkg::SYM_INC: begin
               state_next.cur_cell = eff_cell + 8'd1;
            end
            tli_pkg::SYM_DEC: begin
               state_next.cur_cell = eff_cell - 8'd1;
            end
            tli_pkg::SYM_RIGHT: begin
               if (state_ff.cell_ptr == tli_pkg::TAPE_TOP) begin
                  err = tli_pkg::ERR_TOP;
               end else begin
                  tape_raw.wr_en          = 1'b1;
                  tape_raw.rd_en          = 1'b1;
                  tape_raw.rd_addr        = cp_up[tli_pkg::TAPE_AW-1:0];
                  state_next.cell_ptr     = cp_up[tli_pkg::TAPE_AW-1:0];
                  state_next.filled       = filled_grow;
                  state_next.load_pending = 1'b1;
                  state_next.load_fresh   = (state_ff.filled <= cp_up);
               end
            end
            tli_pkg::SYM_LEFT: begin
               if (state_ff.cell_ptr == '0) begin
                  err = tli_pkg::ERR_BOTTOM;
               end else begin
                  tape_raw.wr_en          = 1'b1;
                  tape_raw.rd_en          = 1'b1;
                  tape_raw.rd_addr        = state_ff.cell_ptr - tli_pkg::TAPE_AW'(1);
                  state_next.cell_ptr     = state_ff.cell_ptr - tli_pkg::TAPE_AW'(1);
                  state_next.filled       = filled_grow;
                  state_next.load_pending = 1'b1;
               end
            end
            tli_pkg::SYM_PRINT: begin
               result.print_valid = 1'b1;
               result.print_byte  = eff_cell;
            end
            tli_pkg::SYM_OPEN: begin
               if (eff_cell == 8'd0) begin
                  state_next.skip_depth = tli_pkg::SKIP_W'(1);
               end else if (stack_status.full) begin
                  err = tli_pkg::ERR_STACK_FULL;
               end else begin
                  stack_raw.push = 1'b1;
               end
            end
            tli_pkg::SYM_CLOSE: begin
               if (stack_status.empty) begin
                  err = tli_pkg::ERR_UNMATCHED;
               end else if (eff_cell == 8'd0) begin
                  stack_raw.pop = 1'b1;
               end else begin
                  result.next_position = stack_status.top;
               end
            end
            default: begin
            end
         endcase
      end

      if (err != tli_pkg::ERR_NONE) begin
         state_next.halt      = 1'b1;
         result.next_position = item.position;
      end
      result.error_code = err;
      result.halted     = state_next.halt;
   end

   always_comb begin
      state_in         = execute ? state_next : state_ff;
      tape_cmd         = tape_raw;
      tape_cmd.wr_en   = tape_raw.wr_en & execute;
      tape_cmd.rd_en   = tape_raw.rd_en & execute;
      stack_cmd        = stack_raw;
      stack_cmd.push   = stack_raw.push & execute;
      stack_cmd.pop    = stack_raw.pop & execute;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '0;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// File: hdl/tape_language_interpreter_core.sv
// Tape language interpreter core.
// The req_ channel carries one program symbol and its position per transfer; the
// rsp_ channel returns one result per symbol: the position to fetch next, an
// optional printed byte, an error code and the sticky halted flag.
// A symbol taken at one clock edge is held in an input register, executed against
// the tape, pointer, loop stack and skip counter once the output register is free,
// and its result is registered into the output register and offered on rsp_.
// Throughput is one symbol per cycle while rsp_stall is low; the current cell sits in a
// register, and a pointer move writes it back to the tape memory while the single read
// port fetches the neighbor, which the next symbol picks up from the read register.
// In practice the fetcher needs next_position before it can send the following
// symbol, so in a closed loop of fetcher and core each symbol waits for the last result.
// Reset clears the pointer, loop stack count, skip counter and halt flag, and the
// tape reads as all zero right away: a fill mark tracks which cells were ever
// written, so no clearing pass is needed. When rsp_stall is high the result is
// held, the input register holds its symbol and req_stall rises once it is full.
module tape_language_interpreter_core (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  tli_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output tli_pkg::rsp_type rsp_data
);

   logic                       hold_valid_ff;
   logic                       hold_valid_in;
   tli_pkg::req_type           hold_item_ff;
   logic                       rsp_valid_ff;
   logic                       rsp_valid_in;
   tli_pkg::rsp_type           rsp_data_ff;
   logic                       advance;
   logic                       execute;
   tli_pkg::rsp_type           exec_result;
   tli_pkg::tape_cmd_type      tape_cmd;
   tli_pkg::stack_cmd_type     stack_cmd;
   tli_pkg::stack_status_type  stack_status;
   logic [7:0]                 tape_rd_data;

   // Output register frees up when empty or when its transfer completes
   assign advance   = !rsp_valid_ff || !rsp_stall;
   assign execute   = hold_valid_ff && advance;
   assign req_stall = hold_valid_ff && !advance;

   // Input register: take a new symbol when empty or whenever the held one moves on
   assign hold_valid_in = req_stall ? hold_valid_ff : req_valid;
   assign rsp_valid_in  = advance ? hold_valid_ff : rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         hold_valid_ff <= hold_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         hold_item_ff <= req_data;
      end
   end

   always_ff @(posedge clock) begin
      if (execute) begin
         rsp_data_ff <= exec_result;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   tli_exec u_exec (
      .clock        (clock),
      .reset        (reset),
      .execute      (execute),
      .item         (hold_item_ff),
      .rd_data      (tape_rd_data),
      .stack_status (stack_status),
      .result       (exec_result),
      .tape_cmd     (tape_cmd),
      .stack_cmd    (stack_cmd)
   );

   tli_tape_ram u_tape (
      .clock   (clock),
      .cmd     (tape_cmd),
      .rd_data (tape_rd_data)
   );

   tli_loop_stack u_stack (
      .clock  (clock),
      .reset  (reset),
      .cmd    (stack_cmd),
      .status (stack_status)
   );

   // A fault always comes with the halt flag set
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_data.error_code != tli_pkg::ERR_NONE)) |-> rsp_data.halted)
      else $error("fault result without halted");

   // Once halted, every later result stays halted
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_stall && rsp_data.halted) |=> rsp_data.halted)
      else $error("halt flag dropped");

   // A printing symbol never faults
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.print_valid) |-> (rsp_data.error_code == tli_pkg::ERR_NONE))
      else $error("print combined with fault");

   // Stack push and pop never fire together
   assert property (@(posedge clock) disable iff (reset)
      !(stack_cmd.push && stack_cmd.pop))
      else $error("loop stack push and pop together");

endmodule
